>>> src/sti_pkg.sv
// Shared constants, codes and types for the sorted table with insert and search.
`timescale 1ns / 1ps

package sti_pkg;

    // Default sizes handed to the top-level parameters
    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_BITS_DEF  = 64;
    localparam int DATA_BITS_DEF = 32;

    // Fixed port field widths
    localparam int MODE_W   = 2;
    localparam int KEY_W    = 64;
    localparam int ENTRY_W  = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    // Command broadcast from the sequencer to every cell
    typedef struct packed {
        logic capture;  // compare stored key with the search key, load scan stage
        logic scan;     // move scan stage one cell toward the head
        logic insert;   // shift entries at and above the insertion point up by one
    } t_cell_cmd;

endpackage

>>> src/sti_cell.sv
// One table cell: holds one key/data entry plus a scan stage passed toward the head.
`timescale 1ns / 1ps

module sti_cell #(
    parameter int KEY_BITS  = sti_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS = sti_pkg::DATA_BITS_DEF
) (
    input  logic                  i_clk,
    input  sti_pkg::t_cell_cmd    i_cmd,
    input  logic                  i_valid,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [DATA_BITS-1:0]  i_data,
    input  logic                  i_prev_lt,
    input  logic [KEY_BITS-1:0]   i_prev_key,
    input  logic [DATA_BITS-1:0]  i_prev_data,
    input  logic                  i_next_scan_lt,
    input  logic                  i_next_scan_eq,
    input  logic [DATA_BITS-1:0]  i_next_scan_data,
    output logic                  o_lt,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [DATA_BITS-1:0]  o_data,
    output logic                  o_scan_lt,
    output logic                  o_scan_eq,
    output logic [DATA_BITS-1:0]  o_scan_data
);

    logic [KEY_BITS-1:0]  r_key;
    logic [DATA_BITS-1:0] r_data;
    logic                 r_lt;
    logic                 r_scan_lt;
    logic                 r_scan_eq;
    logic [DATA_BITS-1:0] r_scan_data;
    logic                 n_lt;
    logic                 n_eq;

    // Compare stored key against the broadcast search key
    assign n_lt = i_valid && (r_key < i_key);
    assign n_eq = i_valid && (r_key == i_key);

    // Hold the entry; on insert, take the new entry at the boundary or the lower neighbor's
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && !r_lt) begin
            r_key  <= i_prev_lt ? i_key  : i_prev_key;
            r_data <= i_prev_lt ? i_data : i_prev_data;
        end
    end

    // Load the scan stage on capture, advance it toward the head on scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_lt        <= n_lt;
            r_scan_lt   <= n_lt;
            r_scan_eq   <= n_eq;
            r_scan_data <= r_data;
        end else if (i_cmd.scan) begin
            r_scan_lt   <= i_next_scan_lt;
            r_scan_eq   <= i_next_scan_eq;
            r_scan_data <= i_next_scan_data;
        end
    end

    assign o_lt        = r_lt;
    assign o_key       = r_key;
    assign o_data      = r_data;
    assign o_scan_lt   = r_scan_lt;
    assign o_scan_eq   = r_scan_eq;
    assign o_scan_data = r_scan_data;

endmodule

>>> src/sorted_table_insert_search.sv
// Top level: sequencer and chain of cells forming a sorted key/data table.
`timescale 1ns / 1ps

// Sorted key/data table built as a row of CAPACITY cells, one entry per cell, kept in
// ascending unsigned key order. A lookup or insert compares every cell against the key at
// once, then walks the compare flags down the chain to the head one cell per cycle
// until the first entry not below the key: that walk sets the latency. A stored insert
// adds an insert step after the walk; a clear skips the compare and the walk. One item is
// worked at a time; the next input transfer is taken while a finished result still waits
// in the output register. No clearing pass is needed after reset.
module sorted_table_insert_search #(
    parameter int CAPACITY  = sti_pkg::CAPACITY_DEF,
    parameter int KEY_BITS  = sti_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS = sti_pkg::DATA_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sti_pkg::MODE_W-1:0]    i_mode,
    input  logic [sti_pkg::KEY_W-1:0]     i_key,
    input  logic [sti_pkg::ENTRY_W-1:0]   i_entry_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [sti_pkg::POS_W-1:0]     o_position,
    output logic [sti_pkg::STATUS_W-1:0]  o_status,
    output logic [sti_pkg::ENTRY_W-1:0]   o_data_out,
    output logic [sti_pkg::POS_W-1:0]     o_entry_total
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAPTURE,
        S_SCAN,
        S_INSERT,
        S_FINISH
    } t_state;

    t_state                         r_state;
    logic [sti_pkg::MODE_W-1:0]     r_mode;
    logic [KEY_BITS-1:0]            r_key;
    logic [DATA_BITS-1:0]           r_din;
    logic [CNT_W-1:0]               r_count;
    logic [CNT_W-1:0]               r_pos;
    logic                           r_hit;
    logic [sti_pkg::STATUS_W-1:0]   r_status;
    logic [DATA_BITS-1:0]           r_dout;
    logic                           r_out_valid;
    logic                           r_o_found;
    logic [sti_pkg::POS_W-1:0]      r_o_position;
    logic [sti_pkg::STATUS_W-1:0]   r_o_status;
    logic [sti_pkg::ENTRY_W-1:0]    r_o_data_out;
    logic [sti_pkg::POS_W-1:0]      r_o_entry_total;

    sti_pkg::t_cell_cmd             w_cmd;
    logic                           w_in_xfer;
    logic                           w_out_free;
    logic                           w_lookup;
    logic                           w_full;

    logic [CAPACITY-1:0]            w_lt;
    logic [KEY_BITS-1:0]            w_key  [CAPACITY];
    logic [DATA_BITS-1:0]           w_data [CAPACITY];
    logic [CAPACITY:0]              w_slt;
    logic [CAPACITY:0]              w_seq;
    logic [DATA_BITS-1:0]           w_sdata [CAPACITY+1];

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_lookup   = (r_mode != sti_pkg::MODE_INSERT);
    assign w_full     = (r_count >= CNT_W'(CAPACITY));

    // Drive cell commands from the sequencer state
    always_comb begin
        w_cmd.capture = (r_state == S_CAPTURE);
        w_cmd.scan    = (r_state == S_SCAN) && w_slt[0];
        w_cmd.insert  = (r_state == S_INSERT);
    end

    // Feed zeros into the tail of the scan chain
    assign w_slt[CAPACITY]   = 1'b0;
    assign w_seq[CAPACITY]   = 1'b0;
    assign w_sdata[CAPACITY] = '0;

    // Build the row of cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                 w_prev_lt;
        logic [KEY_BITS-1:0]  w_prev_key;
        logic [DATA_BITS-1:0] w_prev_data;

        if (i == 0) begin : g_head
            assign w_prev_lt   = 1'b1;
            assign w_prev_key  = '0;
            assign w_prev_data = '0;
        end else begin : g_body
            assign w_prev_lt   = w_lt[i-1];
            assign w_prev_key  = w_key[i-1];
            assign w_prev_data = w_data[i-1];
        end

        sti_cell #(
            .KEY_BITS  (KEY_BITS),
            .DATA_BITS (DATA_BITS)
        ) u_cell (
            .i_clk            (i_clk),
            .i_cmd            (w_cmd),
            .i_valid          (CNT_W'(i) < r_count),
            .i_key            (r_key),
            .i_data           (r_din),
            .i_prev_lt        (w_prev_lt),
            .i_prev_key       (w_prev_key),
            .i_prev_data      (w_prev_data),
            .i_next_scan_lt   (w_slt[i+1]),
            .i_next_scan_eq   (w_seq[i+1]),
            .i_next_scan_data (w_sdata[i+1]),
            .o_lt             (w_lt[i]),
            .o_key            (w_key[i]),
            .o_data           (w_data[i]),
            .o_scan_lt        (w_slt[i]),
            .o_scan_eq        (w_seq[i]),
            .o_scan_data      (w_sdata[i])
        );
    end

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once it has been transferred, unless a new one replaces it
            if (r_out_valid && i_out_ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_mode   <= i_mode;
                        r_key    <= i_key[KEY_BITS-1:0];
                        r_din    <= DATA_BITS'(i_entry_data);
                        r_pos    <= '0;
                        r_hit    <= 1'b0;
                        r_status <= sti_pkg::STATUS_OK;
                        r_dout   <= '0;
                        if (i_mode == sti_pkg::MODE_CLEAR) begin
                            r_count <= '0;
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_CAPTURE;
                        end
                    end
                end

                S_CAPTURE: begin
                    r_state <= S_SCAN;
                end

                S_SCAN: begin
                    // advance past entries below the key; stop at the first that is not
                    if (w_slt[0]) begin
                        r_pos <= r_pos + CNT_W'(1);
                    end else begin
                        r_hit <= w_seq[0];
                        if (w_lookup) begin
                            r_dout  <= w_seq[0] ? w_sdata[0] : '0;
                            r_state <= S_FINISH;
                        end else if (w_full) begin
                            r_status <= sti_pkg::STATUS_FULL;
                            r_state  <= S_FINISH;
                        end else if (w_seq[0]) begin
                            r_status <= sti_pkg::STATUS_DUP;
                            r_state  <= S_FINISH;
                        end else begin
                            r_state <= S_INSERT;
                        end
                    end
                end

                S_INSERT: begin
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_FINISH;
                end

                S_FINISH: begin
                    // hold until the result register is free
                    if (w_out_free) begin
                        r_out_valid     <= 1'b1;
                        r_o_found       <= r_hit;
                        r_o_position    <= sti_pkg::POS_W'(r_pos);
                        r_o_status      <= r_status;
                        r_o_data_out    <= sti_pkg::ENTRY_W'(r_dout);
                        r_o_entry_total <= sti_pkg::POS_W'(r_count);
                        r_state         <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_found       = r_o_found;
    assign o_position    = r_o_position;
    assign o_status      = r_o_status;
    assign o_data_out    = r_o_data_out;
    assign o_entry_total = r_o_entry_total;

endmodule

>>> dv/sti_table_scoreboard_pkg.sv
// Scoreboard class for the sorted table: tracks table contents and checks each result.
`timescale 1ns / 1ps

package sti_table_scoreboard_pkg;

    import sti_pkg::*;

    localparam int TABLE_DEPTH = CAPACITY_DEF;

    typedef struct packed {
        logic                found;
        logic [POS_W-1:0]    position;
        logic [STATUS_W-1:0] status;
        logic [ENTRY_W-1:0]  data_out;
        logic [POS_W-1:0]    entry_total;
    } table_reply_t;

    class sorted_table_tracker;
        logic [KEY_W-1:0]   keys [TABLE_DEPTH];
        logic [ENTRY_W-1:0] payloads [TABLE_DEPTH];
        int unsigned        count = 0;
        int unsigned        mismatches = 0;
        table_reply_t       expected_replies [$];

        // Apply one accepted transfer to the shadow table and queue its reply
        function void record_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                     logic [ENTRY_W-1:0] payload);
            table_reply_t reply;
            int unsigned  lo;
            int unsigned  hi;
            int unsigned  mid;
            reply = '0;
            if (mode == MODE_CLEAR) begin
                count = 0;
            end else begin
                // Lower-bound search: first entry whose key is not below the search key
                lo = 0;
                hi = count;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (keys[mid] < key) lo = mid + 1;
                    else hi = mid;
                end
                reply.found    = (lo < count) && (keys[lo] == key);
                reply.position = POS_W'(lo);
                if (mode == MODE_INSERT) begin
                    // Full table wins over duplicate key
                    if (count >= TABLE_DEPTH) begin
                        reply.status = STATUS_FULL;
                    end else if (reply.found) begin
                        reply.status = STATUS_DUP;
                    end else begin
                        for (int i = count; i > lo; i--) begin
                            keys[i]     = keys[i-1];
                            payloads[i] = payloads[i-1];
                        end
                        keys[lo]     = key;
                        payloads[lo] = payload;
                        count++;
                    end
                end else if (reply.found) begin
                    // Lookup, or the unused selector acting as one
                    reply.data_out = payloads[lo];
                end
            end
            reply.entry_total = POS_W'(count);
            expected_replies.push_back(reply);
        endfunction

        function void compare_field(string name, logic [ENTRY_W-1:0] expv,
                                    logic [ENTRY_W-1:0] actv);
            if (actv !== expv) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
                mismatches++;
            end
        endfunction

        // Match one result transfer against the oldest pending reply
        function void check_reply(table_reply_t got);
            table_reply_t want;
            if (expected_replies.size() == 0) begin
                $error("result: expected none, got 0x%0h", got);
                mismatches++;
            end else begin
                want = expected_replies.pop_front();
                compare_field("found", ENTRY_W'(want.found), ENTRY_W'(got.found));
                compare_field("position", ENTRY_W'(want.position), ENTRY_W'(got.position));
                compare_field("status", ENTRY_W'(want.status), ENTRY_W'(got.status));
                compare_field("data_out", want.data_out, got.data_out);
                compare_field("entry_total", ENTRY_W'(want.entry_total),
                              ENTRY_W'(got.entry_total));
            end
        endfunction

        function int unsigned outstanding();
            return expected_replies.size();
        endfunction
    endclass

endpackage

>>> dv/sorted_table_insert_search_tb.sv
// Testbench top: drives lookups, inserts and clears into the sorted table and checks results.
`timescale 1ns / 1ps

module sorted_table_insert_search_tb;

    import sti_pkg::*;
    import sti_table_scoreboard_pkg::*;

    localparam int unsigned STALL_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES  = 80;
    localparam int unsigned PHASE_ITEMS   = 130;

    // Unused selector, answered as a lookup
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [MODE_W-1:0]   i_mode;
    logic [KEY_W-1:0]    i_key;
    logic [ENTRY_W-1:0]  i_entry_data;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic                o_found;
    logic [POS_W-1:0]    o_position;
    logic [STATUS_W-1:0] o_status;
    logic [ENTRY_W-1:0]  o_data_out;
    logic [POS_W-1:0]    o_entry_total;

    sorted_table_tracker tracker = new();

    int unsigned send_idle_pct = 12;
    int unsigned recv_idle_pct = 51;
    int unsigned sent_items    = 0;
    int unsigned stall_left    = 0;
    bit          stall_request = 1'b0;

    sorted_table_insert_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .i_entry_data  (i_entry_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_position    (o_position),
        .o_status      (o_status),
        .o_data_out    (o_data_out),
        .o_entry_total (o_entry_total)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Check result transfers and drive the receiver's ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_reply({o_found, o_position, o_status, o_data_out, o_entry_total});
        end
        if (stall_request) begin
            stall_left    = STALL_CYCLES;
            stall_request = 1'b0;
        end
        if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one item, idling at random first; valid stays high on return
    task automatic send_item(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                             logic [ENTRY_W-1:0] payload);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_key        <= key;
        i_entry_data <= payload;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.record_request(mode, key, payload);
        sent_items++;
    endtask

    // Hold the sender until every pending result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    // Mix of present keys, their neighbors, extremes and fresh random keys
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned      sel;
        logic [KEY_W-1:0] near;
        sel = $urandom_range(99);
        if (tracker.count > 0) begin
            near = tracker.keys[$urandom_range(tracker.count - 1)];
            if (sel < 35) return near;
            if (sel < 42) return near + 1'b1;
            if (sel < 48) return near - 1'b1;
        end
        if (sel < 51) return '0;
        if (sel < 54) return '1;
        if (sel < 66) return {$urandom, 32'h0};
        return {$urandom, $urandom};
    endfunction

    task automatic random_item();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 50) send_item(MODE_INSERT, pick_key(), $urandom);
        else if (sel < 93) send_item(MODE_LOOKUP, pick_key(), $urandom);
        else if (sel < 97) send_item(MODE_SPARE, pick_key(), $urandom);
        else send_item(MODE_CLEAR, {$urandom, $urandom}, $urandom);
    endtask

    // One burst of traffic; a fill burst first packs the table to capacity
    task automatic run_round(bit fill);
        int unsigned n;
        n = $urandom_range(8, 40);
        if (fill) begin
            while (tracker.count < TABLE_DEPTH) send_item(MODE_INSERT, pick_key(), $urandom);
            // Full table: refuse both a present key and a new one
            send_item(MODE_INSERT, tracker.keys[$urandom_range(TABLE_DEPTH - 1)], $urandom);
            send_item(MODE_INSERT, {$urandom, $urandom}, $urandom);
        end
        repeat (n) random_item();
        if ($urandom_range(1) == 0) send_item(MODE_CLEAR, {$urandom, $urandom}, $urandom);
    endtask

    task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, bit with_stall);
        int unsigned phase_end;
        bit          first;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        phase_end     = sent_items + PHASE_ITEMS;
        first         = 1'b1;
        while (sent_items < phase_end) begin
            if (with_stall && first) stall_request = 1'b1;
            run_round(first || ($urandom_range(3) == 0));
            first = 1'b0;
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_mode       <= MODE_LOOKUP;
        i_key        <= '0;
        i_entry_data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, extreme keys and payloads, hits, misses,
        // duplicate, unused selector, clear
        send_item(MODE_LOOKUP, '0, '1);
        send_item(MODE_INSERT, '1, '1);
        send_item(MODE_INSERT, '0, '0);
        send_item(MODE_INSERT, 64'h8000_0000_0000_0000, 32'hA5A5_A5A5);
        send_item(MODE_INSERT, 64'h4142_4300_0000_0000, 32'h5A5A_5A5A);
        send_item(MODE_LOOKUP, '1, '0);
        send_item(MODE_LOOKUP, '0, '1);
        send_item(MODE_LOOKUP, 64'h1, '0);
        send_item(MODE_LOOKUP, 64'h4142_4300_0000_0000, '0);
        send_item(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, '0);
        send_item(MODE_INSERT, '1, 32'h1234_5678);
        send_item(MODE_INSERT, 64'h4142_4300_0000_0000, '0);
        send_item(MODE_SPARE, 64'h8000_0000_0000_0000, '1);
        send_item(MODE_SPARE, 64'h7FFF_FFFF_FFFF_FFFF, '1);
        send_item(MODE_CLEAR, '1, '1);
        send_item(MODE_LOOKUP, '1, '0);
        send_item(MODE_INSERT, 64'h0000_0000_0000_0001, 32'h0000_0001);
        send_item(MODE_CLEAR, '0, '0);
        wait_drained();

        // Random traffic in three idling regimes; long receiver hold-off in the first two
        run_phase(12, 51, 1'b1);
        run_phase(51, 12, 1'b1);
        run_phase(0, 0, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
src/sti_pkg.sv
src/sti_cell.sv
src/sorted_table_insert_search.sv
dv/sti_table_scoreboard_pkg.sv
dv/sorted_table_insert_search_tb.sv
